[sv/circular_double_ended_queue_top_macros.svh]
// Assertion macros shared by the queue RTL.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/cdq_pkg.sv]
package cdq_pkg;

	localparam int DEPTH     = 16;
	localparam int ELEM_BITS = 32;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [ELEM_BITS-1:0] elem_t;
	typedef logic [2:0]           func_t;
	typedef logic [1:0]           status_t;
	typedef logic [1:0]           cell_op_t;

	// request function codes
	localparam func_t FN_PUSH_BACK  = 3'd0;
	localparam func_t FN_PUSH_FRONT = 3'd1;
	localparam func_t FN_POP_BACK   = 3'd2;
	localparam func_t FN_POP_FRONT  = 3'd3;
	localparam func_t FN_READ       = 3'd4;
	localparam func_t FN_CLEAR      = 3'd5;

	// result status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	// per-cell update codes
	localparam cell_op_t OP_HOLD = 2'd0;
	localparam cell_op_t OP_LOAD = 2'd1;
	localparam cell_op_t OP_UP   = 2'd2;
	localparam cell_op_t OP_DOWN = 2'd3;

	typedef struct packed {
		cell_op_t op;
		idx_t     wr_idx;
		logic     rd_en;
		idx_t     rd_idx;
	} cell_cmd_t;

endpackage

[sv/cdq_cell.sv]
module cdq_cell (
	input  logic              clk,
	input  cdq_pkg::idx_t     idx,
	input  cdq_pkg::cell_cmd_t cmd,
	input  cdq_pkg::elem_t    load_data,
	input  cdq_pkg::elem_t    prev_data,
	input  cdq_pkg::elem_t    next_data,
	input  cdq_pkg::elem_t    rd_chain_in,
	output cdq_pkg::elem_t    data,
	output cdq_pkg::elem_t    rd_chain_out
);
	import cdq_pkg::*;

	elem_t data_q;

	// hold, load at the write index, or take a neighbor's element
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				if (idx == cmd.wr_idx) data_q <= load_data;
			end
			OP_UP:   data_q <= prev_data;
			OP_DOWN: data_q <= next_data;
			default: ;
		endcase
	end

	assign data = data_q;
	// merge own element into the read chain when selected
	assign rd_chain_out = (cmd.rd_en && (idx == cmd.rd_idx)) ? (rd_chain_in | data_q)
		: rd_chain_in;

endmodule

[sv/cdq_ctrl.sv]
`include "circular_double_ended_queue_top_macros.svh"

module cdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  cdq_pkg::func_t     func,
	input  cdq_pkg::idx_t      position,
	output cdq_pkg::cell_cmd_t cmd,
	output cdq_pkg::status_t   status,
	output cdq_pkg::cnt_t      count_next
);
	import cdq_pkg::*;

	cnt_t      count_q;
	cnt_t      cnt_d;
	cell_cmd_t cmd_d;
	status_t   st_d;
	logic      full;
	logic      empty;

	assign full  = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd_d  = '{op: OP_HOLD, wr_idx: count_q[IDX_BITS-1:0], rd_en: 1'b0, rd_idx: '0};
		st_d   = ST_OK;
		cnt_d  = count_q;
		case (func)
			FN_PUSH_BACK: begin
				if (full) st_d = ST_FULL;
				else begin
					cmd_d.op = OP_LOAD;
					cnt_d    = count_q + 1'b1;
				end
			end
			FN_PUSH_FRONT: begin
				if (full) st_d = ST_FULL;
				else begin
					cmd_d.op = OP_UP;
					cnt_d    = count_q + 1'b1;
				end
			end
			FN_POP_BACK: begin
				if (empty) st_d = ST_EMPTY;
				else begin
					cmd_d.rd_en  = 1'b1;
					cmd_d.rd_idx = IDX_BITS'(count_q - 1'b1);
					cnt_d        = count_q - 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (empty) st_d = ST_EMPTY;
				else begin
					cmd_d.rd_en = 1'b1;
					cmd_d.op    = OP_DOWN;
					cnt_d       = count_q - 1'b1;
				end
			end
			FN_READ: begin
				if (CNT_BITS'(position) >= count_q) st_d = ST_RANGE;
				else begin
					cmd_d.rd_en  = 1'b1;
					cmd_d.rd_idx = position;
				end
			end
			FN_CLEAR: cnt_d = '0;
			default: ;
		endcase
		// drop cell updates unless the request is taken
		if (!accept) cmd_d.op = OP_HOLD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (accept) count_q <= cnt_d;
	end

	assign cmd        = cmd_d;
	assign status     = st_d;
	assign count_next = cnt_d;

	`CDQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_BITS'(DEPTH), "count above capacity")
	`CDQ_ASSERT_NEXT(a_count_idle, !accept, $stable(count_q), "count moved without request")
	`CDQ_ASSERT_NOW(a_read_ok, cmd_d.rd_en, st_d == ST_OK, "cell read on a failed request")

endmodule

[sv/circular_double_ended_queue_top.sv]
// Fixed-capacity double-ended queue of 32-bit elements, 16 deep.
// Request channel: in_valid / in_stall with func, data_in, position. A request
// is taken at a clock edge where in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with status, data_out, occupancy.
// Functions: push back, push front, pop back, pop front, read at a position
// counted from the front, clear. Codes six and seven leave the queue alone.
// Elements sit in a row of cells in logical order: cell 0 holds the front.
// Push front and pop front shift the whole row by one cell at once;
// push back loads the cell at the count; reads come through an OR chain.
// The result is registered and appears in the cycle after its request is taken.
// Throughput: one request per cycle while the receiver does not stall, set by the
// row update and the output register; the output register frees when its result is taken.
// When the receiver stalls, the result holds and in_stall rises until it is
// taken. Reset empties the queue; cell contents are not cleared and are never
// read before being written.
`include "circular_double_ended_queue_top_macros.svh"

module circular_double_ended_queue_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cdq_pkg::func_t      func,
	input  cdq_pkg::elem_t      data_in,
	input  cdq_pkg::idx_t       position,
	output logic                out_valid,
	input  logic                out_stall,
	output cdq_pkg::status_t    status,
	output cdq_pkg::elem_t      data_out,
	output cdq_pkg::cnt_t       occupancy
);
	import cdq_pkg::*;

	logic      in_acc;
	cell_cmd_t cmd;
	status_t   st_d;
	cnt_t      cnt_d;
	elem_t     cell_data [DEPTH];
	elem_t     rd_chain  [DEPTH+1];

	logic      out_valid_q;
	status_t   status_q;
	elem_t     data_q;
	cnt_t      occ_q;

	// stall requests only while a finished result waits on a stalled receiver
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	cdq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_acc),
		.func       (func),
		.position   (position),
		.cmd        (cmd),
		.status     (st_d),
		.count_next (cnt_d)
	);

	assign rd_chain[0] = '0;

	// row of cells; cell 0 takes the pushed element on a shift toward the back
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		elem_t prev_w;
		elem_t next_w;
		if (k == 0) begin : g_first
			assign prev_w = data_in;
		end else begin : g_mid
			assign prev_w = cell_data[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign next_w = cell_data[k];
		end else begin : g_inner
			assign next_w = cell_data[k+1];
		end
		cdq_cell u_cell (
			.clk          (clk),
			.idx          (IDX_BITS'(k)),
			.cmd          (cmd),
			.load_data    (data_in),
			.prev_data    (prev_w),
			.next_data    (next_w),
			.rd_chain_in  (rd_chain[k]),
			.data         (cell_data[k]),
			.rd_chain_out (rd_chain[k+1])
		);
	end

	// output register: valid is control, payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (in_acc) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= st_d;
			data_q   <= (st_d == ST_OK) ? rd_chain[DEPTH] : '0;
			occ_q    <= cnt_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign occupancy = occ_q;

	`CDQ_ASSERT_NEXT(a_accept_valid, in_acc, out_valid_q, "taken request left no result")
	`CDQ_ASSERT_NOW(a_bad_zero, out_valid_q && (status_q != ST_OK), data_q == '0,
		"failed result carries data")
	`CDQ_ASSERT_NOW(a_occ_bound, out_valid_q, occ_q <= CNT_BITS'(DEPTH), "occupancy too high")

endmodule
